### hw/rtl/voxh_pkg.sv
package voxh_pkg;

    // Default geometry (table depth must be a power of two)
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int AXIS_BITS_DEF   = 21;

    // Murmur finalizer multipliers
    localparam logic [63:0] HASH_M1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] HASH_M2 = 64'hc4ceb9fe1a85ec53;
    localparam int          HASH_SH = 33;

    // Configuration register indexes
    localparam logic [1:0] REG_INV_SCALE = 2'd0;
    localparam logic [1:0] REG_SAT_LIMIT = 2'd1;
    localparam logic [1:0] REG_MAX_OCC   = 2'd2;

    // Configuration reset values
    localparam logic [31:0] INV_SCALE_RST = 32'd6553600;
    localparam logic [15:0] SAT_LIMIT_RST = 16'd4;
    localparam logic [12:0] MAX_OCC_RST   = 13'd2867;

    // Verdict codes
    localparam logic [2:0] VERD_KEPT_OLD  = 3'd0;
    localparam logic [2:0] VERD_KEPT_NEW  = 3'd1;
    localparam logic [2:0] VERD_SATURATED = 3'd2;
    localparam logic [2:0] VERD_FULL      = 3'd3;
    localparam logic [2:0] VERD_RANGE     = 3'd4;
    localparam logic [2:0] VERD_CLEARED   = 3'd5;

    // Opcodes
    localparam logic OP_FUSE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // 33x33 signed multiplier operands
    typedef logic signed [32:0] mul_op_t;
    typedef logic signed [65:0] mul_res_t;

endpackage

### hw/rtl/voxel_hash_saturating_filter_top.sv
// Fuse beat: axis products (S_MX..S_KEY), hash rounds (S_HA..S_HD), read/compare loop
// (S_PRD, S_PCMP) per slot probed, then S_OUT; out of range skips from S_KEY to S_OUT.
// Clear beat: S_CLR over every slot, then S_OUT. One beat is in work at a time; a finished
// result may wait in the output register while the next beat is taken. Pace set by the
// single shared 33x33 multiplier (3 axis + 6 hash products) and the read/compare loop of
// the table RAM. After reset the table tags are swept to zero before the first beat.
module voxel_hash_saturating_filter_top
    import voxh_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AXIS_BITS   = AXIS_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // pos_x, pos_y, pos_z
    input  logic         s_tuser,   // opcode
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_x, out_y, out_z, hit_count, occupied_slots, pad
    output logic [3:0]   m_tuser,   // verdict, kept
    // configuration
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int KEY_W  = 3 * AXIS_BITS;
    localparam int WORD_W = 24 + KEY_W;
    localparam int TOP_W  = 33 - AXIS_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_MX   = 4'd2;
    localparam logic [3:0] S_MY   = 4'd3;
    localparam logic [3:0] S_MZ   = 4'd4;
    localparam logic [3:0] S_KEY  = 4'd5;
    localparam logic [3:0] S_HA   = 4'd6;
    localparam logic [3:0] S_HB   = 4'd7;
    localparam logic [3:0] S_HC   = 4'd8;
    localparam logic [3:0] S_HD   = 4'd9;
    localparam logic [3:0] S_PRD  = 4'd10;
    localparam logic [3:0] S_PCMP = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]  state_reg, state_next;

    // configuration registers
    logic [31:0] inv_scale_reg;
    logic [15:0] sat_limit_reg;
    logic [12:0] max_occ_reg;

    // item registers
    logic [31:0] px_reg, py_reg, pz_reg;
    logic [KEY_W-1:0] key_reg;
    logic        oor_reg;
    logic [63:0] v_reg;
    logic [63:0] acc_reg;
    logic        round_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] n_reg;
    logic [7:0]  tag_reg;
    logic [12:0] occ_reg;
    logic        clr_out_reg;
    logic [2:0]  verd_reg;
    logic        kept_reg;
    logic [15:0] hits_reg;

    // result register
    logic        m_valid_reg;
    logic [127:0] m_data_reg;
    logic [3:0]  m_user_reg;

    // shared multiplier
    mul_op_t  mul_a, mul_b;
    mul_res_t prod_reg;
    logic [63:0] prod;
    logic [63:0] mconst;

    // RAM
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic [7:0]        rd_tag;
    logic [KEY_W-1:0]  rd_key;
    logic [15:0]       rd_cnt;

    logic [63:0] hsum, hnext;
    logic [TOP_W-1:0] ax_top;
    logic        ax_ok;
    logic [AXIS_BITS-1:0] ax_bias;
    logic [31:0] cur_pos;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign prod   = prod_reg[63:0];
    assign mconst = round_reg ? HASH_M2 : HASH_M1;

    assign rd_tag = ram_rdata[7:0];
    assign rd_key = ram_rdata[KEY_W+7:8];
    assign rd_cnt = ram_rdata[WORD_W-1:KEY_W+8];

    // axis index from the previous product: floor = upper word
    assign ax_top  = prod[63:31+AXIS_BITS];
    assign ax_ok   = (&ax_top) | ~(|ax_top);
    assign ax_bias = {~prod[31+AXIS_BITS], prod[30+AXIS_BITS:32]};

    // second half of a 64-bit low product, then the xor-shift
    assign hsum  = acc_reg + {prod[31:0], 32'd0};
    assign hnext = hsum ^ (hsum >> HASH_SH);

    // multiplier operand select
    always_comb
    begin
        cur_pos = px_reg;
        case (state_reg)
            S_MY:    cur_pos = py_reg;
            S_MZ:    cur_pos = pz_reg;
            default: cur_pos = px_reg;
        endcase
        case (state_reg)
            S_MX, S_MY, S_MZ:
            begin
                mul_a = {cur_pos[31], cur_pos};
                mul_b = {1'b0, inv_scale_reg};
            end
            S_HA:
            begin
                mul_a = {1'b0, v_reg[31:0]};
                mul_b = {1'b0, mconst[31:0]};
            end
            S_HB:
            begin
                mul_a = {1'b0, v_reg[31:0]};
                mul_b = {1'b0, mconst[63:32]};
            end
            S_HC:
            begin
                mul_a = {1'b0, v_reg[63:32]};
                mul_b = {1'b0, mconst[31:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    voxh_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    // table RAM: {count, key, tag}
    always_comb
    begin
        ram_raddr = idx_reg;
        ram_waddr = idx_reg;
        ram_we    = 1'b0;
        ram_wdata = '0;
        if (state_reg == S_CLR)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_PCMP)
        begin
            if (rd_tag != 8'd0 && rd_tag == tag_reg && rd_key == key_reg)
            begin
                ram_we    = (rd_cnt < sat_limit_reg);
                ram_wdata = {rd_cnt + 16'd1, rd_key, rd_tag};
            end
            else if (rd_tag == 8'd0)
            begin
                ram_we    = ({1'b0, occ_reg} + 14'd1 <= {1'b0, max_occ_reg});
                ram_wdata = {16'd1, key_reg, tag_reg};
            end
        end
    end

    voxh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_scale_reg <= INV_SCALE_RST;
            sat_limit_reg <= SAT_LIMIT_RST;
            max_occ_reg   <= MAX_OCC_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_INV_SCALE: inv_scale_reg <= cfg_data;
                REG_SAT_LIMIT: sat_limit_reg <= cfg_data[15:0];
                REG_MAX_OCC:   max_occ_reg   <= cfg_data[12:0];
                default:       ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_tvalid)
                    state_next = (s_tuser == OP_CLEAR) ? S_CLR : S_MX;
            S_CLR:
                if (idx_reg == {IDX_W{1'b1}})
                    state_next = clr_out_reg ? S_OUT : S_IDLE;
            S_MX:   state_next = S_MY;
            S_MY:   state_next = S_MZ;
            S_MZ:   state_next = S_KEY;
            S_KEY:  state_next = (oor_reg || !ax_ok) ? S_OUT : S_HA;
            S_HA:   state_next = S_HB;
            S_HB:   state_next = S_HC;
            S_HC:   state_next = S_HD;
            S_HD:   state_next = round_reg ? S_PRD : S_HA;
            S_PRD:  state_next = S_PCMP;
            S_PCMP:
                if (rd_tag == 8'd0 || (rd_tag == tag_reg && rd_key == key_reg)
                    || n_reg == {IDX_W{1'b1}})
                    state_next = S_OUT;
                else
                    state_next = S_PRD;
            S_OUT:
                if (!m_valid_reg || m_tready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            idx_reg     <= '0;
            clr_out_reg <= 1'b0;
            occ_reg     <= '0;
            round_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // drained beat; a new one loaded in S_OUT takes its place
            if (m_valid_reg && m_tready && state_reg != S_OUT)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                    if (s_tvalid)
                    begin
                        px_reg      <= s_tdata[31:0];
                        py_reg      <= s_tdata[63:32];
                        pz_reg      <= s_tdata[95:64];
                        idx_reg     <= '0;
                        clr_out_reg <= 1'b1;
                        oor_reg     <= 1'b0;
                        round_reg   <= 1'b0;
                        kept_reg    <= 1'b0;
                        hits_reg    <= '0;
                    end
                S_CLR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == {IDX_W{1'b1}})
                    begin
                        occ_reg  <= '0;
                        verd_reg <= VERD_CLEARED;
                    end
                end
                S_MY:
                begin
                    key_reg[AXIS_BITS-1:0] <= ax_bias;
                    oor_reg <= ~ax_ok;
                end
                S_MZ:
                begin
                    key_reg[2*AXIS_BITS-1:AXIS_BITS] <= ax_bias;
                    oor_reg <= oor_reg | ~ax_ok;
                end
                S_KEY:
                begin
                    key_reg[KEY_W-1:2*AXIS_BITS] <= ax_bias;
                    v_reg    <= {{(64 - KEY_W){1'b0}}, ax_bias, key_reg[2*AXIS_BITS-1:0]}
                              ^ ({{(64 - KEY_W){1'b0}}, ax_bias, key_reg[2*AXIS_BITS-1:0]}
                                 >> HASH_SH);
                    verd_reg <= VERD_RANGE;
                end
                S_HB: acc_reg <= prod;
                S_HC: acc_reg <= acc_reg + {prod[31:0], 32'd0};
                S_HD:
                begin
                    v_reg     <= hnext;
                    round_reg <= 1'b1;
                    idx_reg   <= hnext[IDX_W-1:0];
                    tag_reg   <= (hnext[63:56] == 8'd0) ? 8'd1 : hnext[63:56];
                    n_reg     <= '0;
                end
                S_PCMP:
                begin
                    if (rd_tag != 8'd0 && rd_tag == tag_reg && rd_key == key_reg)
                    begin
                        if (rd_cnt < sat_limit_reg)
                        begin
                            verd_reg <= VERD_KEPT_OLD;
                            kept_reg <= 1'b1;
                            hits_reg <= rd_cnt + 16'd1;
                        end
                        else
                        begin
                            verd_reg <= VERD_SATURATED;
                            hits_reg <= rd_cnt;
                        end
                    end
                    else if (rd_tag == 8'd0)
                    begin
                        if ({1'b0, occ_reg} + 14'd1 <= {1'b0, max_occ_reg})
                        begin
                            verd_reg <= VERD_KEPT_NEW;
                            kept_reg <= 1'b1;
                            hits_reg <= 16'd1;
                            occ_reg  <= occ_reg + 13'd1;
                        end
                        else
                        begin
                            verd_reg <= VERD_FULL;
                        end
                    end
                    else
                    begin
                        verd_reg <= VERD_FULL;
                        idx_reg  <= idx_reg + 1'b1;
                        n_reg    <= n_reg + 1'b1;
                    end
                end
                S_OUT:
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= {kept_reg, verd_reg};
                        m_data_reg  <= {3'd0, occ_reg, hits_reg,
                                        kept_reg ? pz_reg : 32'd0,
                                        kept_reg ? py_reg : 32'd0,
                                        kept_reg ? px_reg : 32'd0};
                    end
                default: ;
            endcase
        end
    end

endmodule

### hw/rtl/voxh_ram.sv
module voxh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/voxh_mul.sv
module voxh_mul
    import voxh_pkg::*;
(
    input  logic     clk,
    input  mul_op_t  a,
    input  mul_op_t  b,
    output mul_res_t prod_reg
);

    // Shared signed multiplier, result registered
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

### tb/tb_voxel_hash_saturating_filter_top.sv
`timescale 1ns / 100ps

module tb_voxel_hash_saturating_filter_top
    import voxh_pkg::*;
();

    localparam int DEPTH      = 4096;
    localparam int AXB        = 21;
    localparam int CYC_LIMIT  = 1500000;
    localparam int N_PHASE    = 6;
    localparam int PHASE_BEATS = 272;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        kept;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] hits;
        logic [12:0] occ;
    } voxel_res_t;

    typedef struct packed {
        logic        op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        typed;
        voxel_res_t  res;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    // side info that travels with the beat on offer
    logic         cur_typed;
    voxel_res_t   cur_res;

    // shadow of the block's registers and table
    logic [31:0]  sh_scale;
    logic [15:0]  sh_sat;
    logic [12:0]  sh_maxocc;
    logic [7:0]   sh_tag [DEPTH];
    logic [62:0]  sh_key [DEPTH];
    logic [15:0]  sh_cnt [DEPTH];
    int           sh_occ;

    voxel_res_t   verdict_q[$];
    int           mismatches;
    int           cycles;
    bit           hold_req;
    bit           no_idle;
    logic [31:0]  pool [16][3];

    voxel_hash_saturating_filter_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // murmur finalizer
    function automatic logic [63:0] mix64(input logic [63:0] v);
        v = v ^ (v >> HASH_SH);
        v = v * HASH_M1;
        v = v ^ (v >> HASH_SH);
        v = v * HASH_M2;
        v = v ^ (v >> HASH_SH);
        return v;
    endfunction

    // predicted result of one beat; updates the shadow table
    function automatic voxel_res_t fuse_predict(input logic op, input logic [31:0] px,
                                                input logic [31:0] py, input logic [31:0] pz);
        voxel_res_t  r;
        logic [31:0] p [3];
        longint      prod;
        longint      b [3];
        bit          oor;
        logic [62:0] key;
        logic [63:0] h;
        logic [7:0]  tg;
        int          idx;
        int          n;
        bit          found;
        bit          empty;
        r = '0;
        oor = 0;
        found = 0;
        empty = 0;
        if (op == OP_CLEAR)
        begin
            for (int i = 0; i < DEPTH; i++) sh_tag[i] = '0;
            sh_occ = 0;
            r.verdict = VERD_CLEARED;
            return r;
        end
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        for (int a = 0; a < 3; a++)
        begin
            prod = longint'($signed(p[a])) * longint'({32'd0, sh_scale});
            b[a] = (prod >>> 32) + (longint'(1) << (AXB - 1));
            if (b[a] < 0 || b[a] > (longint'(1) << AXB) - 1) oor = 1;
        end
        if (oor)
        begin
            r.verdict = VERD_RANGE;
        end
        else
        begin
            key = {b[2][AXB-1:0], b[1][AXB-1:0], b[0][AXB-1:0]};
            h = mix64({1'b0, key});
            tg = h[63:56];
            if (tg == 8'd0) tg = 8'd1;
            idx = int'(h[11:0]);
            for (n = 0; n < DEPTH; n++)
            begin
                if (sh_tag[idx] == 8'd0)
                begin
                    empty = 1;
                    break;
                end
                if (sh_tag[idx] == tg && sh_key[idx] == key)
                begin
                    found = 1;
                    break;
                end
                idx = (idx + 1) % DEPTH;
            end
            if (found)
            begin
                if (sh_cnt[idx] >= sh_sat)
                    r.verdict = VERD_SATURATED;
                else
                begin
                    sh_cnt[idx] = sh_cnt[idx] + 16'd1;
                    r.verdict = VERD_KEPT_OLD;
                    r.kept = 1'b1;
                end
                r.hits = sh_cnt[idx];
            end
            else if (!empty || sh_occ + 1 > int'(sh_maxocc))
            begin
                r.verdict = VERD_FULL;
            end
            else
            begin
                sh_tag[idx] = tg;
                sh_key[idx] = key;
                sh_cnt[idx] = 16'd1;
                sh_occ++;
                r.verdict = VERD_KEPT_NEW;
                r.kept = 1'b1;
                r.hits = 16'd1;
            end
        end
        if (r.kept)
        begin
            r.x = px;
            r.y = py;
            r.z = pz;
        end
        r.occ = sh_occ[12:0];
        return r;
    endfunction

    // monitor: check results, predict accepted beats, track config writes
    always @(posedge clk)
    begin
        voxel_res_t got;
        voxel_res_t want;
        got = '0;
        want = '0;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.verdict = m_tuser[2:0];
            got.kept    = m_tuser[3];
            got.x       = m_tdata[31:0];
            got.y       = m_tdata[63:32];
            got.z       = m_tdata[95:64];
            got.hits    = m_tdata[111:96];
            got.occ     = m_tdata[124:112];
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: verdict %0d/%0d kept %0d/%0d hits %0d/%0d occ %0d/%0d",
                                 want.verdict, got.verdict, want.kept, got.kept,
                                 want.hits, got.hits, want.occ, got.occ);
                        $display("  x %h/%h y %h/%h z %h/%h",
                                 want.x, got.x, want.y, got.y, want.z, got.z);
                    end
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            want = fuse_predict(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
            if (cur_typed) want = cur_res;
            verdict_q = {verdict_q, want};
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_INV_SCALE: sh_scale  = cfg_data;
                REG_SAT_LIMIT: sh_sat    = cfg_data[15:0];
                REG_MAX_OCC:   sh_maxocc = cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // run length guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("[voxel_hash_saturating_filter_top] ERROR");
            $finish;
        end
    end

    // result side backpressure
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_beat(input logic op, input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic typed, input voxel_res_t res);
        bit rdy;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= op;
        s_tdata   <= {pz, py, px};
        cur_typed <= typed;
        cur_res   <= res;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end while (!rdy);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        bit rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end while (!rdy);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] narrow_rand();
        int w;
        logic [31:0] v;
        w = $urandom_range(2, 28);
        v = $urandom;
        v = v & ((32'd1 << w) - 1);
        if (v[w-1]) v = v | ~((32'd1 << w) - 1);
        return v;
    endfunction

    function automatic voxel_res_t mk(input logic [2:0] v, input logic k, input logic [31:0] x,
                                      input logic [15:0] hits, input logic [12:0] occ);
        voxel_res_t r;
        r.verdict = v;
        r.kept = k;
        r.x = x;
        r.y = '0;
        r.z = '0;
        r.hits = hits;
        r.occ = occ;
        return r;
    endfunction

    dir_row_t    dir_tbl [$];
    logic [31:0] cfg_scale [N_PHASE];
    logic [15:0] cfg_sat   [N_PHASE];
    logic [12:0] cfg_occ   [N_PHASE];

    // append one row to the directed table
    function automatic void add_row(input dir_row_t row);
        dir_tbl = {dir_tbl, row};
    endfunction

    initial
    begin
        voxel_res_t nores;
        int r;
        int k;
        logic [31:0] px, py, pz;
        nores = '0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_FUSE;
        cfg_valid = 1'b0;
        cfg_index = REG_INV_SCALE;
        cfg_data = '0;
        cur_typed = 1'b0;
        cur_res = '0;
        cycles = 0;
        mismatches = 0;
        hold_req = 0;
        no_idle = 0;
        sh_scale = INV_SCALE_RST;
        sh_sat = SAT_LIMIT_RST;
        sh_maxocc = MAX_OCC_RST;
        sh_occ = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sh_tag[i] = '0;
            sh_key[i] = '0;
            sh_cnt[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: defaults, saturation, range edges, clear
        add_row({OP_CLEAR, 32'd0, 32'd0, 32'd0, 1'b1, mk(VERD_CLEARED, 0, 0, 0, 0)});
        add_row({OP_FUSE, 32'd0, 32'd0, 32'd0, 1'b1, mk(VERD_KEPT_NEW, 1, 0, 1, 1)});
        add_row({OP_FUSE, 32'd0, 32'd0, 32'd0, 1'b1, mk(VERD_KEPT_OLD, 1, 0, 2, 1)});
        add_row({OP_FUSE, 32'd0, 32'd0, 32'd0, 1'b1, mk(VERD_KEPT_OLD, 1, 0, 3, 1)});
        add_row({OP_FUSE, 32'd0, 32'd0, 32'd0, 1'b1, mk(VERD_KEPT_OLD, 1, 0, 4, 1)});
        add_row({OP_FUSE, 32'd0, 32'd0, 32'd0, 1'b1, mk(VERD_SATURATED, 0, 0, 4, 1)});
        add_row({OP_FUSE, 32'h7fffffff, 32'd0, 32'd0, 1'b1,
                 mk(VERD_RANGE, 0, 0, 0, 1)});
        add_row({OP_FUSE, 32'd0, 32'h80000000, 32'd0, 1'b1,
                 mk(VERD_RANGE, 0, 0, 0, 1)});
        add_row({OP_FUSE, 32'd0, 32'd0, 32'hffffffff, 1'b0, nores});
        add_row({OP_FUSE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, nores});
        add_row({OP_FUSE, 32'd687194767, 32'd0, 32'd0, 1'b0, nores});
        add_row({OP_FUSE, 32'd687194768, 32'd0, 32'd0, 1'b0, nores});
        add_row({OP_FUSE, -32'sd687194767, 32'd0, 32'd0, 1'b0, nores});
        add_row({OP_FUSE, -32'sd687194768, 32'd0, 32'd0, 1'b0, nores});
        add_row({OP_FUSE, 32'd655, 32'd656, -32'sd1, 1'b0, nores});
        add_row({OP_FUSE, 32'h5555aaaa, 32'haaaa5555, 32'h12345678, 1'b0, nores});
        add_row({OP_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1,
                 mk(VERD_CLEARED, 0, 0, 0, 0)});
        add_row({OP_FUSE, 32'd0, 32'd0, 32'd0, 1'b1, mk(VERD_KEPT_NEW, 1, 0, 1, 1)});
        foreach (dir_tbl[i])
            send_beat(dir_tbl[i].op, dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].z,
                      dir_tbl[i].typed, dir_tbl[i].res);
        drain();

        // zero scale and zero saturation limit: every point lands in voxel zero, all dropped
        write_reg(REG_INV_SCALE, 32'd0);
        write_reg(REG_SAT_LIMIT, 32'd0);
        for (int i = 0; i < 4; i++)
            send_beat(OP_FUSE, $urandom, $urandom, $urandom, 1'b0, nores);
        drain();

        // register settings per random phase, extremes included
        cfg_scale = '{32'd6553600, 32'd1, 32'hffffffff, 32'd65536, 32'd6553600, 32'd1310720};
        cfg_sat   = '{16'd4, 16'd1, 16'd65535, 16'd2, 16'd3, 16'd6};
        cfg_occ   = '{13'd2867, 13'd1, 13'd4096, 13'd48, 13'd24, 13'd300};

        for (int ph = 0; ph < N_PHASE; ph++)
        begin
            write_reg(REG_INV_SCALE, cfg_scale[ph]);
            write_reg(REG_SAT_LIMIT, {16'd0, cfg_sat[ph]});
            write_reg(REG_MAX_OCC, {19'd0, cfg_occ[ph]});
            if (ph == N_PHASE - 1) no_idle = 1;
            for (int i = 0; i < 16; i++)
                for (int a = 0; a < 3; a++) pool[i][a] = narrow_rand();
            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                if (ph == 1 && i == 40) hold_req = 1;
                if (ph == 2 && i == 100) drain();
                r = $urandom_range(0, 99);
                k = $urandom_range(0, 15);
                px = pool[k][0];
                py = pool[k][1];
                pz = pool[k][2];
                if (r < 2)
                    send_beat(OP_CLEAR, $urandom, $urandom, $urandom, 1'b0, nores);
                else if (r < 62)
                    send_beat(OP_FUSE, px ^ $urandom_range(0, 3), py, pz, 1'b0, nores);
                else if (r < 74)
                    send_beat(OP_FUSE, narrow_rand(), narrow_rand(), narrow_rand(), 1'b0, nores);
                else if (r < 90)
                    send_beat(OP_FUSE, $urandom, $urandom, $urandom, 1'b0, nores);
                else
                begin
                    for (int a = 0; a < 3; a++) pool[k][a] = narrow_rand();
                    send_beat(OP_FUSE, pool[k][0], pool[k][1], pool[k][2], 1'b0, nores);
                end
            end
            drain();
        end

        while (verdict_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("[voxel_hash_saturating_filter_top] OK");
        else
            $display("[voxel_hash_saturating_filter_top] ERROR");
        $finish;
    end

endmodule
